// ===== rtl/core/dtcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcw_pkg: shared types and tables for the date/time check and weekday core
// Request and result structs, range limits, month tables and a small
// modulo-7 reduction used by the weekday path.
// ----------------------------------------------------------------------------
package dtcw_pkg;

    localparam logic [13:0] YEAR_MIN     = 14'd2000;
    localparam logic [13:0] YEAR_MAX     = 14'd2099;
    localparam logic [4:0]  HOUR_MAX     = 5'd23;
    localparam logic [4:0]  PM_HOUR      = 5'd12;
    localparam logic [5:0]  MIN_SEC_MAX  = 6'd59;
    localparam logic [7:0]  BASE_WEEKDAY = 8'd5;   // 2000-01-01, Saturday
    localparam logic [3:0]  MONTH_FEB    = 4'd2;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_dtcw_in;

    typedef struct packed {
        logic       status;
        logic [6:0] year_offset;
        logic [2:0] weekday;
        logic       is_pm;
    } t_dtcw_out;

    // Check outcome handed from the validator to the weekday path
    typedef struct packed {
        logic       ok;
        logic       leap;
        logic [6:0] year_offset;
        logic       is_pm;
    } t_dtcw_chk;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd2: begin
                    len = leap ? 5'd29 : 5'd28;
                end
                4'd4, 4'd6, 4'd9, 4'd11: begin
                    len = 5'd30;
                end
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                    len = 5'd31;
                end
                default: begin
                    len = 5'd0;
                end
            endcase
            return len;
        end
    endfunction

    // Days before the first of the month, reduced modulo 7
    function automatic logic [2:0] month_offset_mod7(input logic [3:0] month);
        logic [2:0] r;
        begin
            case (month)
                4'd1:    r = 3'd0;
                4'd2:    r = 3'd3;
                4'd3:    r = 3'd3;
                4'd4:    r = 3'd6;
                4'd5:    r = 3'd1;
                4'd6:    r = 3'd4;
                4'd7:    r = 3'd6;
                4'd8:    r = 3'd2;
                4'd9:    r = 3'd5;
                4'd10:   r = 3'd0;
                4'd11:   r = 3'd3;
                4'd12:   r = 3'd5;
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

    // 8 = 1 mod 7, so fold octal digits twice and correct once
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] f1;
        logic [3:0] f2;
        begin
            f1 = {2'b00, x[2:0]} + {2'b00, x[5:3]} + {3'b000, x[7:6]};
            f2 = {1'b0, f1[2:0]} + {2'b00, f1[4:3]};
            if (f2 >= 4'd7) begin
                f2 = f2 - 4'd7;
            end
            return f2[2:0];
        end
    endfunction

endpackage

// ===== rtl/core/dtcw_validate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcw_validate: range check of one date and time request
// Flags any field out of range, applies the leap rule and derives the year
// offset and the afternoon flag.
// ----------------------------------------------------------------------------
module dtcw_validate
    import dtcw_pkg::*;
(
    input  t_dtcw_in  i_request,
    output t_dtcw_chk o_chk
);

    logic [13:0] year_diff;
    logic        year_ok;
    logic        month_ok;
    logic        day_ok;
    logic        time_ok;
    logic        leap;

    assign year_diff = i_request.year - YEAR_MIN;
    assign year_ok   = (i_request.year >= YEAR_MIN) && (i_request.year <= YEAR_MAX);
    assign month_ok  = (i_request.month >= 4'd1) && (i_request.month <= 4'd12);

    // 2000 is divisible by 400, and 2100 lies outside the range
    assign leap      = (year_diff[1:0] == 2'b00);

    assign day_ok    = (i_request.day >= 5'd1) &&
                       (i_request.day <= month_length(i_request.month, leap));
    assign time_ok   = (i_request.hour <= HOUR_MAX) &&
                       (i_request.minute <= MIN_SEC_MAX) &&
                       (i_request.second <= MIN_SEC_MAX);

    assign o_chk.ok          = year_ok && month_ok && day_ok && time_ok;
    assign o_chk.leap        = leap;
    assign o_chk.year_offset = year_diff[6:0];
    assign o_chk.is_pm       = (i_request.hour >= PM_HOUR);

endmodule

// ===== rtl/core/dtcw_weekday.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcw_weekday: day of week for a checked date
// Sums the day count modulo 7 from the year offset, month and day; each
// year adds one weekday since 365 = 1 mod 7.
// ----------------------------------------------------------------------------
module dtcw_weekday
    import dtcw_pkg::*;
(
    input  logic [6:0] i_year_offset,
    input  logic       i_leap,
    input  logic [3:0] i_month,
    input  logic [4:0] i_day,
    output logic [2:0] o_weekday
);

    logic [7:0] leap_days;
    logic [7:0] day_sum;
    logic       leap_adj;

    // leap days in 2000..year-1
    assign leap_days = ({1'b0, i_year_offset} + 8'd3) >> 2;
    assign leap_adj  = i_leap && (i_month > MONTH_FEB);

    assign day_sum = {1'b0, i_year_offset} + leap_days
                   + {5'd0, month_offset_mod7(i_month)}
                   + {7'd0, leap_adj}
                   + ({3'd0, i_day} - 8'd1)
                   + BASE_WEEKDAY;

    assign o_weekday = mod7(day_sum) + 3'd1;

endmodule

// ===== rtl/core/date_time_check_weekday_core.sv =====
`timescale 1ns / 1ps
// A request taken at a clock edge is registered in r_in and r_vld; its result
// and strobe (o_done) are then registered in r_out and r_done.
// Throughput: one request per cycle; busy stays low, set by the single
// register-to-register pass through the check and weekday logic.
// Reset (synchronous, active low) clears the valid flags; no result follows.
// ----------------------------------------------------------------------------
// date_time_check_weekday_core: calendar date and time check with weekday
// Registers the request, validates every field, computes the weekday and
// registers one result per request.
// ----------------------------------------------------------------------------
module date_time_check_weekday_core
    import dtcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_dtcw_in  i_request,
    output logic      o_done,
    output t_dtcw_out o_result
);

    logic      r_vld;
    t_dtcw_in  r_in;
    logic      r_done;
    t_dtcw_out r_out;
    t_dtcw_out n_out;
    t_dtcw_chk chk;
    logic [2:0] weekday;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in <= i_request;
        end
    end

    dtcw_validate u_validate (
        .i_request (r_in),
        .o_chk     (chk)
    );

    dtcw_weekday u_weekday (
        .i_year_offset (chk.year_offset),
        .i_leap        (chk.leap),
        .i_month       (r_in.month),
        .i_day         (r_in.day),
        .o_weekday     (weekday)
    );

    // drop every result field but status when the request is out of range
    always_comb begin
        n_out.status      = !chk.ok;
        n_out.year_offset = chk.ok ? chk.year_offset : 7'd0;
        n_out.weekday     = chk.ok ? weekday : 3'd0;
        n_out.is_pm       = chk.ok ? chk.is_pm : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_rst_n, 2)) |-> (o_done == $past(start, 2)))
        else $error("result strobe does not follow request by two cycles");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status) |->
        (o_result.year_offset == 7'd0 && o_result.weekday == 3'd0 && !o_result.is_pm))
        else $error("error result carries non-zero fields");

    a_valid_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.status) |->
        (o_result.weekday != 3'd0 && o_result.year_offset <= 7'd99))
        else $error("valid result has weekday or year offset out of range");

    a_pm_from_hour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && chk.ok) |=> (o_result.is_pm == ($past(r_in.hour) >= PM_HOUR)))
        else $error("afternoon flag does not match the request hour");
`endif

endmodule
